FILE: rtl/tst_pkg.sv
// tab stop table: shared types, codes and constants
// used by tst_ctrl, tst_datapath and tab_stop_table_top; no dependencies
package tst_pkg;

  localparam int COL_W           = 9;
  localparam int OP_W            = 3;
  localparam int S_DATA_W        = 24;
  localparam int M_DATA_W        = 16;
  localparam int NUM_COLUMNS_DEF = 256;
  localparam int WORD_BITS_DEF   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SET_STOP   = 3'd0,
    OP_CLEAR_STOP = 3'd1,
    OP_CLEAR_ALL  = 3'd2,
    OP_EIGHTH     = 3'd3,
    OP_FWD_TAB    = 3'd4,
    OP_BACK_TAB   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCAN_FIRST,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;      // latch the input word
    logic start;        // load scan pointer at its first word
    logic back;         // scan direction for start
    logic step;         // advance scan pointer
    logic fill_wr;      // write fill pattern at scan pointer
    logic fill_eighth;  // pattern: every eighth column, else zero
    logic finish;       // latch scan result, write edited word
    logic load_out;     // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  in_op;        // operation of the offered input word
    logic in_col_ok;    // offered column lies inside the table
    logic hit;          // evaluated word holds a qualifying bit
    logic ev_last;      // evaluated word is the last in scan order
    logic at_last;      // scan pointer is at the last word
  } status_t;

endpackage

FILE: rtl/tst_datapath.sv
// tab stop table datapath: stop word memory, scan pointer, bit search, output register
// depends on tst_pkg
module tst_datapath
  import tst_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  cmd_t                cmd,
  output status_t             status,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int NUM_WORDS = (NUM_COLUMNS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int D_W       = ((BASE_W > COL_W) ? BASE_W : COL_W) + 1;
  localparam int PW        = $clog2(WORD_BITS);
  localparam logic [AW-1:0]     LAST_IDX  = AW'(NUM_WORDS - 1);
  localparam logic [BASE_W-1:0] LAST_BASE = BASE_W'((NUM_WORDS - 1) * WORD_BITS);
  localparam logic [BASE_W-1:0] STEP_BASE = BASE_W'(WORD_BITS);
  localparam logic [COL_W-1:0]  END_COL   = COL_W'(NUM_COLUMNS - 1);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;

  op_t               op;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  lim;
  logic [COL_W-1:0]  res;
  logic [COL_W-1:0]  out_col;
  logic              out_moved;

  logic              scan_back;
  logic [AW-1:0]     scan_idx;
  logic [BASE_W-1:0] scan_base;
  logic [AW-1:0]     ev_idx;
  logic [BASE_W-1:0] ev_base;

  logic signed [D_W-1:0] col_offset;
  logic [WORD_BITS-1:0]  qual;
  logic [WORD_BITS-1:0]  masked;
  logic [WORD_BITS-1:0]  pattern;
  logic [PW-1:0]         pos;
  logic                  hit;
  logic                  is_edit;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [COL_W-1:0] clamped;
  logic             moved_next;

  // input word decode for the controller
  assign status.in_op     = op_t'(s_tdata[OP_W-1:0]);
  assign status.in_col_ok = ({1'b0, s_tdata[OP_W +: COL_W]} < (COL_W + 1)'(NUM_COLUMNS));
  assign status.hit       = hit;
  assign status.ev_last   = scan_back ? (ev_idx == '0) : (ev_idx == LAST_IDX);
  assign status.at_last   = (scan_idx == LAST_IDX);

  assign is_edit = (op == OP_SET_STOP) || (op == OP_CLEAR_STOP);

  // column offset of the evaluated word relative to its base
  assign col_offset = $signed(D_W'(col)) - $signed(D_W'(ev_base));

  always_comb begin
    logic signed [D_W-1:0] iv;
    iv = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      iv = D_W'(i);
      if (is_edit) begin
        qual[i] = (iv == col_offset);
      end else if (scan_back) begin
        qual[i] = (iv < col_offset);
      end else begin
        qual[i] = (iv > col_offset);
      end
    end
  end

  // an edit stops at the word that holds its column, a tab at a qualifying stop
  assign masked = rd_data & qual;
  assign hit    = is_edit ? (|qual) : (|masked);

  // lowest stop for forward, highest for backward
  always_comb begin
    pos = '0;
    if (scan_back) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (masked[i]) pos = PW'(i);
      end
    end else begin
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        if (masked[i]) pos = PW'(i);
      end
    end
  end

  // fill pattern for the word at the scan pointer
  always_comb begin
    logic [BASE_W-1:0] cv;
    cv = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      cv = scan_base + BASE_W'(i);
      pattern[i] = cmd.fill_eighth && (cv[2:0] == 3'd0) &&
                   (cv < BASE_W'(NUM_COLUMNS));
    end
  end

  // single write port: fill sweep or edited word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_idx;
    wr_data = pattern;
    if (cmd.fill_wr) begin
      wr_en = 1'b1;
    end else if (cmd.finish && is_edit && hit) begin
      wr_en   = 1'b1;
      wr_addr = ev_idx;
      wr_data = (op == OP_SET_STOP) ? (rd_data | qual) : (rd_data & ~qual);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[scan_idx];
    ev_idx  <= scan_idx;
    ev_base <= scan_base;
  end

  // scan pointer, saturating at either end
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_back <= 1'b0;
      scan_idx  <= '0;
      scan_base <= '0;
    end else if (cmd.start) begin
      scan_back <= cmd.back;
      scan_idx  <= cmd.back ? LAST_IDX : '0;
      scan_base <= cmd.back ? LAST_BASE : '0;
    end else if (cmd.step) begin
      if (scan_back) begin
        if (scan_idx != '0) begin
          scan_idx  <= scan_idx - AW'(1);
          scan_base <= scan_base - STEP_BASE;
        end
      end else if (scan_idx != LAST_IDX) begin
        scan_idx  <= scan_idx + AW'(1);
        scan_base <= scan_base + STEP_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= op_t'(s_tdata[OP_W-1:0]);
      col <= s_tdata[OP_W +: COL_W];
      lim <= s_tdata[OP_W + COL_W +: COL_W];
    end
    if (cmd.finish) begin
      if (hit) begin
        res <= COL_W'(ev_base + BASE_W'(pos));
      end else begin
        res <= scan_back ? '0 : END_COL;
      end
    end
  end

  // bound and moved flag
  always_comb begin
    clamped    = col;
    moved_next = 1'b0;
    case (op)
      OP_FWD_TAB: begin
        clamped    = (res > lim) ? lim : res;
        moved_next = (clamped > col);
      end
      OP_BACK_TAB: begin
        clamped    = (res < lim) ? lim : res;
        moved_next = (clamped < col);
      end
      default: begin
        clamped    = col;
        moved_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col   <= clamped;
      out_moved <= moved_next;
    end
  end

  assign m_tdata = {(M_DATA_W - COL_W - 1)'(0), out_moved, out_col};

endmodule

FILE: rtl/tst_ctrl.sv
// tab stop table controller: fill sweeps, word scan sequencing, output handshake
// depends on tst_pkg
module tst_ctrl
  import tst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   fill_reply, fill_reply_next;
  logic   fill_eighth, fill_eighth_next;
  logic   out_free;
  logic   is_fill_op, is_tab_op, is_edit_op;

  assign out_free   = !m_tvalid || m_tready;
  assign is_fill_op = (status.in_op == OP_CLEAR_ALL) || (status.in_op == OP_EIGHTH);
  assign is_tab_op  = (status.in_op == OP_FWD_TAB) || (status.in_op == OP_BACK_TAB);
  assign is_edit_op = ((status.in_op == OP_SET_STOP) || (status.in_op == OP_CLEAR_STOP))
                      && status.in_col_ok;

  // next state
  always_comb begin
    state_next       = state;
    fill_reply_next  = fill_reply;
    fill_eighth_next = fill_eighth;
    unique case (state)
      ST_FILL: begin
        if (status.at_last) state_next = fill_reply ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (is_fill_op) begin
            state_next       = ST_FILL;
            fill_reply_next  = 1'b1;
            fill_eighth_next = (status.in_op == OP_EIGHTH);
          end else if (is_tab_op || is_edit_op) begin
            state_next = ST_SCAN_FIRST;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN_FIRST: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.hit || status.ev_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    s_tready    = 1'b0;
    cmd.back    = (status.in_op == OP_BACK_TAB);
    cmd.fill_eighth = fill_eighth;
    unique case (state)
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.step    = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          cmd.start   = 1'b1;
          if (is_fill_op) cmd.back = 1'b0;
        end
      end
      ST_SCAN_FIRST: cmd.step = 1'b1;
      ST_SCAN: begin
        if (status.hit || status.ev_last) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      fill_reply  <= 1'b0;
      fill_eighth <= 1'b1;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      fill_reply  <= fill_reply_next;
      fill_eighth <= fill_eighth_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/tab_stop_table_top.sv
// tab stop table top level: stream ports, controller and datapath
// depends on tst_pkg, tst_ctrl, tst_datapath
//
//   word     direction  handshake          payload
//   command  in         s_tvalid/s_tready  s_tdata: operation, column, limit
//   result   out        m_tvalid/m_tready  m_tdata: new_column, moved
//
// one command at a time; the stop words sit in a memory read one word per cycle
// tab moves and set/clear walk the words from one end, stopping at a hit or the last word
// clear all and every eighth sweep the memory
// after reset a sweep writes the every-eighth pattern, s_tready low
// a finished result waits in the output register while the next command is taken
module tab_stop_table_top
  import tst_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,  // columns in the table, 16 to 512
  parameter int WORD_BITS   = WORD_BITS_DEF     // stop bits per memory word, 8 to 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // operation [2:0], column [11:3], limit [20:12]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // new_column [8:0], moved [9]
);

  cmd_t    cmd;
  status_t status;

  // sequencing: reset and command fill sweeps, idle, word scan, result hand-off
  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // stop memory, bit search, bound clamp and output register
  tst_datapath #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata)
  );

endmodule
